// File: hw/rtl/gha_pkg.sv
// shared widths, request codes and register indexes of the ghash authenticator
package gha_pkg;

    localparam int HALF_W    = 64;
    localparam int BLOCK_W   = 2 * HALF_W;
    localparam int COUNT_W   = 5;
    localparam int TOTAL_W   = 61;
    localparam int TYPE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] BLOCK_BYTES = COUNT_W'(BLOCK_W / 8);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [7:0]         REDUCE_BYTE = 8'he1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_AAD    = 2'd0,
        REQ_CT     = 2'd1,
        REQ_FINISH = 2'd2
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUBKEY_HIGH = 2'd0,
        REG_SUBKEY_LOW  = 2'd1
    } cfg_reg_t;

endpackage

// File: hw/rtl/gha_req_if.sv
// request channel: block transfers and finish commands
interface gha_req_if;

    logic                          valid;
    logic                          ready;
    logic [gha_pkg::TYPE_W-1:0]    req_type;
    logic [gha_pkg::HALF_W-1:0]    block_high;
    logic [gha_pkg::HALF_W-1:0]    block_low;
    logic [gha_pkg::COUNT_W-1:0]   valid_bytes;

    modport source (
        output valid, req_type, block_high, block_low, valid_bytes,
        input  ready
    );

    modport sink (
        input  valid, req_type, block_high, block_low, valid_bytes,
        output ready
    );

endinterface

// File: hw/rtl/gha_tag_if.sv
// result channel: authentication tag transfers
interface gha_tag_if;

    logic                       valid;
    logic                       ready;
    logic [gha_pkg::HALF_W-1:0] tag_high;
    logic [gha_pkg::HALF_W-1:0] tag_low;

    modport source (
        output valid, tag_high, tag_low,
        input  ready
    );

    modport sink (
        input  valid, tag_high, tag_low,
        output ready
    );

endinterface

// File: hw/rtl/ghash_authenticator_core.sv
// GHASH authenticator core: one 128-bit block absorbed per cycle unless stalled, tag on finish
//
// Each request transfer is padded and registered, and in the following cycle the
// accumulator takes (Y xor block) * H through a combinational GF(2^128) multiplier, so
// one request is accepted every cycle unless stalled; AAD and ciphertext byte totals
// saturate at 2^61-1. A finish folds in the length block, multiplies once more, loads
// the tag register as it leaves the stage register and clears the accumulator and both
// totals. The only back-pressure is a finish that meets a tag still waiting to be taken.
// The user must write the subkey through cfg_we/cfg_index/cfg_data while idle; it is unchecked.
module ghash_authenticator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gha_pkg::HALF_W-1:0]    cfg_data,
    gha_req_if.sink                       req,
    gha_tag_if.source                     tag
);

    // gf(2^128) multiply, msb-first bit order
    function automatic logic [gha_pkg::BLOCK_W-1:0] gf_mul(
        input logic [gha_pkg::BLOCK_W-1:0] y,
        input logic [gha_pkg::BLOCK_W-1:0] h
    );
        logic [gha_pkg::BLOCK_W-1:0] z;
        logic [gha_pkg::BLOCK_W-1:0] v;
        z = '0;
        v = h;
        for (int i = 0; i < gha_pkg::BLOCK_W; i++)
        begin
            if (y[gha_pkg::BLOCK_W-1-i])
            begin
                z = z ^ v;
            end
            if (v[0])
            begin
                v = {1'b0, v[gha_pkg::BLOCK_W-1:1]}
                    ^ {gha_pkg::REDUCE_BYTE, {(gha_pkg::BLOCK_W-8){1'b0}}};
            end
            else
            begin
                v = {1'b0, v[gha_pkg::BLOCK_W-1:1]};
            end
        end
        return z;
    endfunction

    function automatic logic [gha_pkg::TOTAL_W-1:0] sat_add(
        input logic [gha_pkg::TOTAL_W-1:0] total,
        input logic [gha_pkg::COUNT_W-1:0] n
    );
        logic [gha_pkg::TOTAL_W:0] s;
        s = {1'b0, total} + {{(gha_pkg::TOTAL_W+1-gha_pkg::COUNT_W){1'b0}}, n};
        return s[gha_pkg::TOTAL_W] ? gha_pkg::TOTAL_MAX : s[gha_pkg::TOTAL_W-1:0];
    endfunction

    logic [gha_pkg::HALF_W-1:0]  subkey_high_reg;
    logic [gha_pkg::HALF_W-1:0]  subkey_low_reg;

    logic                        stage_valid_reg;
    logic [gha_pkg::TYPE_W-1:0]  stage_type_reg;
    logic [gha_pkg::BLOCK_W-1:0] stage_block_reg;
    logic [gha_pkg::COUNT_W-1:0] stage_count_reg;

    logic [gha_pkg::BLOCK_W-1:0] acc_reg;
    logic [gha_pkg::TOTAL_W-1:0] aad_total_reg;
    logic [gha_pkg::TOTAL_W-1:0] ct_total_reg;

    logic                        tag_valid_reg;
    logic [gha_pkg::BLOCK_W-1:0] tag_data_reg;

    logic [gha_pkg::COUNT_W-1:0] count_clamped;
    logic [7:0]                  pad_shift;
    logic [gha_pkg::BLOCK_W-1:0] pad_mask;
    logic                        req_fire;
    logic                        stage_is_finish;
    logic                        stage_fire;
    logic [gha_pkg::BLOCK_W-1:0] mul_in;
    logic [gha_pkg::BLOCK_W-1:0] mul_out;
    logic [gha_pkg::BLOCK_W-1:0] acc_next;
    logic [gha_pkg::TOTAL_W-1:0] aad_total_next;
    logic [gha_pkg::TOTAL_W-1:0] ct_total_next;

    // input padding
    always_comb
    begin
        count_clamped = (req.valid_bytes > gha_pkg::BLOCK_BYTES)
                        ? gha_pkg::BLOCK_BYTES : req.valid_bytes;
        pad_shift     = {(gha_pkg::BLOCK_BYTES - count_clamped), 3'b000};
        pad_mask      = {gha_pkg::BLOCK_W{1'b1}} << pad_shift;
    end

    // stage control
    assign stage_is_finish = (stage_type_reg == gha_pkg::REQ_FINISH);
    assign stage_fire      = stage_valid_reg
                             && (!stage_is_finish || !tag_valid_reg || tag.ready);
    assign req.ready       = !stage_valid_reg || stage_fire;
    assign req_fire        = req.valid && req.ready;

    // accumulator update
    always_comb
    begin
        acc_next       = acc_reg;
        aad_total_next = aad_total_reg;
        ct_total_next  = ct_total_reg;
        mul_in         = stage_block_reg;
        case (stage_type_reg)
            gha_pkg::REQ_FINISH:
            begin
                mul_in = {aad_total_reg, 3'b000, ct_total_reg, 3'b000};
            end
            default:
            begin
                mul_in = stage_block_reg;
            end
        endcase
        mul_out = gf_mul(acc_reg ^ mul_in, {subkey_high_reg, subkey_low_reg});
        if (stage_fire)
        begin
            case (stage_type_reg)
                gha_pkg::REQ_AAD:
                begin
                    acc_next       = mul_out;
                    aad_total_next = sat_add(aad_total_reg, stage_count_reg);
                end
                gha_pkg::REQ_CT:
                begin
                    acc_next      = mul_out;
                    ct_total_next = sat_add(ct_total_reg, stage_count_reg);
                end
                gha_pkg::REQ_FINISH:
                begin
                    acc_next       = '0;
                    aad_total_next = '0;
                    ct_total_next  = '0;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subkey_high_reg <= '0;
            subkey_low_reg  <= '0;
            stage_valid_reg <= 1'b0;
            stage_type_reg  <= '0;
            acc_reg         <= '0;
            aad_total_reg   <= '0;
            ct_total_reg    <= '0;
            tag_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gha_pkg::REG_SUBKEY_HIGH: subkey_high_reg <= cfg_data;
                    gha_pkg::REG_SUBKEY_LOW:  subkey_low_reg  <= cfg_data;
                    default:                  subkey_low_reg  <= subkey_low_reg;
                endcase
            end
            if (req.ready)
            begin
                stage_valid_reg <= req.valid;
                stage_type_reg  <= req.req_type;
            end
            acc_reg       <= acc_next;
            aad_total_reg <= aad_total_next;
            ct_total_reg  <= ct_total_next;
            if (stage_fire && stage_is_finish)
            begin
                tag_valid_reg <= 1'b1;
            end
            else if (tag.ready)
            begin
                tag_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stage_block_reg <= {req.block_high, req.block_low} & pad_mask;
            stage_count_reg <= count_clamped;
        end
        if (stage_fire && stage_is_finish)
        begin
            tag_data_reg <= mul_out;
        end
    end

    assign tag.valid    = tag_valid_reg;
    assign tag.tag_high = tag_data_reg[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W];
    assign tag.tag_low  = tag_data_reg[gha_pkg::HALF_W-1:0];

`ifndef SYNTH
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && stage_is_finish)
        |=> (acc_reg == '0 && aad_total_reg == '0 && ct_total_reg == '0))
        else $error("state not cleared after finish");

    a_finish_loads_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && stage_is_finish) |=> tag_valid_reg)
        else $error("tag not loaded after finish");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (stage_valid_reg && stage_is_finish && tag_valid_reg && !tag.ready))
        else $error("request stalled without a waiting tag");

    a_block_totals_hold_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && !stage_is_finish && tag_valid_reg && !tag.ready) |=> tag_valid_reg)
        else $error("tag lost while absorbing a block");
`endif

endmodule

// File: dv/ghash_authenticator_core_test.sv
// self-checking testbench of the ghash authenticator core: random messages, subkeys and stalls
module ghash_authenticator_core_test;

    localparam logic [gha_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 100;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 193;

    typedef struct packed {
        logic [gha_pkg::TYPE_W-1:0]  kind;
        logic [gha_pkg::HALF_W-1:0]  hi;
        logic [gha_pkg::HALF_W-1:0]  lo;
        logic [gha_pkg::COUNT_W-1:0] nbytes;
    } block_req_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [gha_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gha_pkg::HALF_W-1:0]    cfg_data = '0;

    gha_req_if req_ch ();
    gha_tag_if tag_ch ();

    ghash_authenticator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .tag       (tag_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [gha_pkg::BLOCK_W-1:0] subkey = '0;
    logic [gha_pkg::BLOCK_W-1:0] ghash_acc = '0;
    logic [gha_pkg::TOTAL_W-1:0] aad_bytes = '0;
    logic [gha_pkg::TOTAL_W-1:0] ct_bytes = '0;

    block_req_t                  pending_reqs[$];
    logic [gha_pkg::BLOCK_W-1:0] tags_due[$];
    block_req_t                  offered_req;

    int  queued_items = 0;
    int  errors = 0;
    bit  idle_en = 1'b1;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  gap_left = 0;
    int  quiet_cycles = 0;

    function automatic logic [gha_pkg::BLOCK_W-1:0] gf128_mul(
        input logic [gha_pkg::BLOCK_W-1:0] y,
        input logic [gha_pkg::BLOCK_W-1:0] h
    );
        logic [gha_pkg::BLOCK_W-1:0] z;
        logic [gha_pkg::BLOCK_W-1:0] v;
        z = '0;
        v = h;
        for (int i = 0; i < gha_pkg::BLOCK_W; i++)
        begin
            if (y[gha_pkg::BLOCK_W-1-i])
                z ^= v;
            v = v[0] ? ((v >> 1) ^ {gha_pkg::REDUCE_BYTE, {(gha_pkg::BLOCK_W-8){1'b0}}})
                     : (v >> 1);
        end
        return z;
    endfunction

    function automatic logic [gha_pkg::TOTAL_W-1:0] add_sat(
        input logic [gha_pkg::TOTAL_W-1:0] total,
        input logic [gha_pkg::COUNT_W-1:0] n
    );
        logic [gha_pkg::TOTAL_W:0] s;
        s = {1'b0, total} + {{(gha_pkg::TOTAL_W+1-gha_pkg::COUNT_W){1'b0}}, n};
        return s[gha_pkg::TOTAL_W] ? gha_pkg::TOTAL_MAX : s[gha_pkg::TOTAL_W-1:0];
    endfunction

    function automatic void absorb_request(input block_req_t r);
        logic [gha_pkg::COUNT_W-1:0] n;
        logic [gha_pkg::BLOCK_W-1:0] mask;
        n = (r.nbytes > gha_pkg::BLOCK_BYTES) ? gha_pkg::BLOCK_BYTES : r.nbytes;
        mask = {gha_pkg::BLOCK_W{1'b1}} << (8 * (gha_pkg::BLOCK_BYTES - n));
        case (r.kind)
            gha_pkg::REQ_AAD, gha_pkg::REQ_CT:
            begin
                ghash_acc = gf128_mul(ghash_acc ^ ({r.hi, r.lo} & mask), subkey);
                if (r.kind == gha_pkg::REQ_AAD)
                    aad_bytes = add_sat(aad_bytes, n);
                else
                    ct_bytes = add_sat(ct_bytes, n);
            end
            gha_pkg::REQ_FINISH:
            begin
                ghash_acc = gf128_mul(ghash_acc ^ {aad_bytes, 3'b000, ct_bytes, 3'b000},
                                      subkey);
                tags_due.push_back(ghash_acc);
                ghash_acc = '0;
                aad_bytes = '0;
                ct_bytes = '0;
            end
            default:
                ;
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.req_type    <= '0;
            req_ch.block_high  <= '0;
            req_ch.block_low   <= '0;
            req_ch.valid_bytes <= '0;
            gap_left = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                absorb_request(offered_req);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    offered_req = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= offered_req.kind;
                    req_ch.block_high  <= offered_req.hi;
                    req_ch.block_low   <= offered_req.lo;
                    req_ch.valid_bytes <= offered_req.nbytes;
                    if (idle_en && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 12);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // tag monitor
    always @(posedge clk or negedge rst_n)
    begin : tag_mon
        logic [gha_pkg::BLOCK_W-1:0] want;
        if (!rst_n)
        begin
            tag_ch.ready <= 1'b0;
            hold_left = 0;
            stall_left = 0;
        end
        else
        begin
            if (tag_ch.valid && tag_ch.ready)
            begin
                if (tags_due.size() == 0)
                begin
                    $error("tag transfer with no finish outstanding: %h %h",
                           tag_ch.tag_high, tag_ch.tag_low);
                    errors++;
                end
                else
                begin
                    want = tags_due.pop_front();
                    if (tag_ch.tag_high !== want[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W])
                    begin
                        $error("tag_high mismatch: expected %h, got %h",
                               want[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W], tag_ch.tag_high);
                        errors++;
                    end
                    if (tag_ch.tag_low !== want[gha_pkg::HALF_W-1:0])
                    begin
                        $error("tag_low mismatch: expected %h, got %h",
                               want[gha_pkg::HALF_W-1:0], tag_ch.tag_low);
                        errors++;
                    end
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tag_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                tag_ch.ready <= 1'b0;
            end
            else
            begin
                tag_ch.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (tag_ch.valid && tag_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [gha_pkg::HALF_W-1:0] rand_half();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [gha_pkg::COUNT_W-1:0] tail_bytes();
        return $urandom_range(0, 1) ? gha_pkg::BLOCK_BYTES
                                    : gha_pkg::COUNT_W'($urandom_range(1, 16));
    endfunction

    task automatic queue_req(input logic [gha_pkg::TYPE_W-1:0] kind,
                             input logic [gha_pkg::HALF_W-1:0] hi,
                             input logic [gha_pkg::HALF_W-1:0] lo,
                             input logic [gha_pkg::COUNT_W-1:0] nbytes);
        block_req_t r;
        r.kind = kind;
        r.hi = hi;
        r.lo = lo;
        r.nbytes = nbytes;
        pending_reqs.push_back(r);
        if (kind != REQ_UNUSED)
            queued_items++;
    endtask

    task automatic queue_message(input int max_aad, input int max_ct);
        int n_aad;
        int n_ct;
        n_aad = $urandom_range(0, max_aad);
        n_ct = $urandom_range(0, max_ct);
        for (int i = 0; i < n_aad; i++)
            queue_req(gha_pkg::REQ_AAD, rand_half(), rand_half(),
                      (i == n_aad - 1) ? tail_bytes() : gha_pkg::BLOCK_BYTES);
        for (int i = 0; i < n_ct; i++)
            queue_req(gha_pkg::REQ_CT, rand_half(), rand_half(),
                      (i == n_ct - 1) ? tail_bytes() : gha_pkg::BLOCK_BYTES);
        queue_req(gha_pkg::REQ_FINISH, rand_half(), rand_half(),
                  gha_pkg::COUNT_W'($urandom_range(0, 31)));
    endtask

    task automatic load_subkey(input logic [gha_pkg::BLOCK_W-1:0] h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= gha_pkg::REG_SUBKEY_HIGH;
        cfg_data  <= h[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W];
        @(posedge clk);
        cfg_index <= gha_pkg::REG_SUBKEY_LOW;
        cfg_data  <= h[gha_pkg::HALF_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        subkey = h;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || tags_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        logic [gha_pkg::BLOCK_W-1:0] key;
        int target;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_subkey({$urandom, $urandom, $urandom, $urandom});
        queue_req(gha_pkg::REQ_FINISH, '0, '0, '0);
        queue_req(gha_pkg::REQ_AAD, '1, '1, gha_pkg::BLOCK_BYTES);
        queue_req(gha_pkg::REQ_AAD, '1, '1, 5'd0);
        queue_req(gha_pkg::REQ_CT, rand_half(), rand_half(), 5'd1);
        queue_req(gha_pkg::REQ_CT, '1, '1, 5'd7);
        queue_req(gha_pkg::REQ_CT, '1, '1, 5'd8);
        queue_req(gha_pkg::REQ_CT, '1, '1, 5'd9);
        queue_req(gha_pkg::REQ_CT, '1, '1, 5'd15);
        queue_req(gha_pkg::REQ_CT, '0, '0, gha_pkg::BLOCK_BYTES);
        queue_req(gha_pkg::REQ_AAD, '1, '1, 5'd17);
        queue_req(gha_pkg::REQ_CT, '1, '1, 5'd31);
        queue_req(REQ_UNUSED, rand_half(), rand_half(), 5'd16);
        queue_req(gha_pkg::REQ_FINISH, '1, '1, 5'd31);
        queue_req(gha_pkg::REQ_FINISH, '0, '0, 5'd0);
        queue_req(gha_pkg::REQ_AAD, {1'b1, 63'd0}, 64'd1, gha_pkg::BLOCK_BYTES);
        queue_req(REQ_UNUSED, '1, '1, 5'd31);
        queue_req(gha_pkg::REQ_CT, '1, '1, gha_pkg::BLOCK_BYTES);
        queue_req(gha_pkg::REQ_FINISH, rand_half(), rand_half(), gha_pkg::BLOCK_BYTES);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_en = (p < 8) && (p != 4) && (p != 5);
            case (p)
                0:       key = '0;
                1:       key = '1;
                2:       key = {1'b1, {(gha_pkg::BLOCK_W-1){1'b0}}};
                3:       key = {{(gha_pkg::BLOCK_W-1){1'b0}}, 1'b1};
                default: key = {$urandom, $urandom, $urandom, $urandom};
            endcase
            load_subkey(key);
            // long tag stall while short messages keep coming
            if (p == 5)
                hold_requests++;
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target)
            begin
                if (p == 5)
                    queue_message(1, 1);
                else if ($urandom_range(0, 7) == 0)
                    queue_req(gha_pkg::TYPE_W'($urandom_range(0, 3)), rand_half(),
                              rand_half(), gha_pkg::COUNT_W'($urandom_range(0, 31)));
                else
                    queue_message(4, 8);
            end
            wait_idle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/gha_pkg.sv
hw/rtl/gha_req_if.sv
hw/rtl/gha_tag_if.sv
hw/rtl/ghash_authenticator_core.sv
dv/ghash_authenticator_core_test.sv
